// ===== hdl/hrck_pkg.sv =====
`timescale 1ns / 1ps

package hrck_pkg;

    // Channel width of the incoming pixel (low bits of each channel are used)
    localparam int CHANNEL_BITS = 8;

    // Width of the colour and alpha results
    localparam int OUT_BITS = 8;

    // Hue in 1/16 degree, signed
    localparam int HUE_BITS = 14;

    // Quotient of 960*|diff| / delta never exceeds 960, so ten bits cover it
    localparam int QUO_BITS = 10;

    // 960 = 1024 - 64
    localparam int SCALE_HI_SHIFT = 10;
    localparam int SCALE_LO_SHIFT = 6;

    localparam logic signed [HUE_BITS:0] HUE_FULL_TURN  = 15'sd5760;
    localparam logic signed [HUE_BITS:0] HUE_SECT_GREEN = 15'sd1920;
    localparam logic signed [HUE_BITS:0] HUE_SECT_BLUE  = 15'sd3840;
    localparam logic signed [HUE_BITS:0] HUE_BLACK      = -15'sd16;

    localparam logic [OUT_BITS-1:0] FULL_ALPHA = {OUT_BITS{1'b1}};

    // Configuration port
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_MIN_HUE = 1'b0;
    localparam logic REG_MAX_HUE = 1'b1;

    // Channel that holds the maximum
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Per-pixel control carried along the pipeline
    typedef struct packed {
        sector_t sector;
        logic    neg;    // channel difference below zero
        logic    black;  // all channels zero
        logic    grey;   // non-black with max equal to min
    } ctl_t;

endpackage

// ===== hdl/hrck_front.sv =====
`timescale 1ns / 1ps

module hrck_front #(
    parameter int CHANNEL_BITS = hrck_pkg::CHANNEL_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         pixel_valid,
    output logic                                         pixel_stall,
    input  logic [CHANNEL_BITS-1:0]                      red_in,
    input  logic [CHANNEL_BITS-1:0]                      green_in,
    input  logic [CHANNEL_BITS-1:0]                      blue_in,
    input  logic                                         advance,
    output logic                                         valid,
    output logic [3*CHANNEL_BITS-1:0]                    pixel,
    output logic [CHANNEL_BITS-1:0]                      delta,
    output logic [CHANNEL_BITS+hrck_pkg::SCALE_HI_SHIFT-1:0] dividend,
    output hrck_pkg::ctl_t                               ctl
);

    localparam int CB = CHANNEL_BITS;
    localparam int DB = CB + hrck_pkg::SCALE_HI_SHIFT;

    // stage 1: max, min, sector, difference
    logic              s1_valid_reg;
    logic [3*CB-1:0]   s1_pixel_reg;
    logic [CB-1:0]     s1_delta_reg;
    logic [CB-1:0]     s1_mag_reg;
    hrck_pkg::ctl_t    s1_ctl_reg;

    // stage 2: scaled dividend
    logic              s2_valid_reg;
    logic [3*CB-1:0]   s2_pixel_reg;
    logic [CB-1:0]     s2_delta_reg;
    logic [DB-1:0]     s2_dividend_reg;
    hrck_pkg::ctl_t    s2_ctl_reg;

    logic              adv1;
    logic [CB-1:0]     hi;
    logic [CB-1:0]     lo;
    logic [CB-1:0]     op_a;
    logic [CB-1:0]     op_b;
    hrck_pkg::ctl_t    ctl_next;
    logic [CB-1:0]     mag_next;
    logic [DB-1:0]     dividend_next;

    assign adv1        = !s1_valid_reg || advance;
    assign pixel_stall = !adv1;

    always_comb
    begin
        hi = red_in;
        lo = red_in;
        if (green_in > hi) hi = green_in;
        if (blue_in > hi)  hi = blue_in;
        if (green_in < lo) lo = green_in;
        if (blue_in < lo)  lo = blue_in;

        if (red_in == hi)
        begin
            ctl_next.sector = hrck_pkg::SECT_RED;
            op_a = green_in;
            op_b = blue_in;
        end
        else if (green_in == hi)
        begin
            ctl_next.sector = hrck_pkg::SECT_GREEN;
            op_a = blue_in;
            op_b = red_in;
        end
        else
        begin
            ctl_next.sector = hrck_pkg::SECT_BLUE;
            op_a = red_in;
            op_b = green_in;
        end
        ctl_next.neg   = op_a < op_b;
        ctl_next.black = hi == '0;
        ctl_next.grey  = (hi == lo) && (hi != '0);
        mag_next = ctl_next.neg ? (op_b - op_a) : (op_a - op_b);
    end

    assign dividend_next = (DB'(s1_mag_reg) << hrck_pkg::SCALE_HI_SHIFT)
                         - (DB'(s1_mag_reg) << hrck_pkg::SCALE_LO_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= pixel_valid;
            if (advance)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_pixel_reg <= {red_in, green_in, blue_in};
            s1_delta_reg <= hi - lo;
            s1_mag_reg   <= mag_next;
            s1_ctl_reg   <= ctl_next;
        end
        if (advance)
        begin
            s2_pixel_reg    <= s1_pixel_reg;
            s2_delta_reg    <= s1_delta_reg;
            s2_dividend_reg <= dividend_next;
            s2_ctl_reg      <= s1_ctl_reg;
        end
    end

    assign valid    = s2_valid_reg;
    assign pixel    = s2_pixel_reg;
    assign delta    = s2_delta_reg;
    assign dividend = s2_dividend_reg;
    assign ctl      = s2_ctl_reg;

endmodule

// ===== hdl/hrck_div_step.sv =====
`timescale 1ns / 1ps

module hrck_div_step #(
    parameter int CHANNEL_BITS = hrck_pkg::CHANNEL_BITS,
    parameter int SHIFT        = 0
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              advance,
    input  logic                                              in_valid,
    input  logic [3*CHANNEL_BITS-1:0]                         in_pixel,
    input  logic [CHANNEL_BITS-1:0]                           in_delta,
    input  logic [CHANNEL_BITS+hrck_pkg::SCALE_HI_SHIFT-1:0]  in_rem,
    input  logic [hrck_pkg::QUO_BITS-1:0]                     in_quo,
    input  hrck_pkg::ctl_t                                    in_ctl,
    output logic                                              valid,
    output logic [3*CHANNEL_BITS-1:0]                         pixel,
    output logic [CHANNEL_BITS-1:0]                           delta,
    output logic [CHANNEL_BITS+hrck_pkg::SCALE_HI_SHIFT-1:0]  rem,
    output logic [hrck_pkg::QUO_BITS-1:0]                     quo,
    output hrck_pkg::ctl_t                                    ctl
);

    localparam int CB = CHANNEL_BITS;
    localparam int DB = CB + hrck_pkg::SCALE_HI_SHIFT;
    localparam int QB = hrck_pkg::QUO_BITS;

    logic              valid_reg;
    logic [3*CB-1:0]   pixel_reg;
    logic [CB-1:0]     delta_reg;
    logic [DB-1:0]     rem_reg;
    logic [QB-1:0]     quo_reg;
    hrck_pkg::ctl_t    ctl_reg;

    logic [DB-1:0]     trial;
    logic              fits;

    // one restoring step: try to subtract delta at this bit weight
    assign trial = DB'(in_delta) << SHIFT;
    assign fits  = in_rem >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_reg <= in_pixel;
            delta_reg <= in_delta;
            rem_reg   <= fits ? (in_rem - trial) : in_rem;
            quo_reg   <= {in_quo[QB-2:0], fits};
            ctl_reg   <= in_ctl;
        end
    end

    assign valid = valid_reg;
    assign pixel = pixel_reg;
    assign delta = delta_reg;
    assign rem   = rem_reg;
    assign quo   = quo_reg;
    assign ctl   = ctl_reg;

endmodule

// ===== hdl/hrck_back.sv =====
`timescale 1ns / 1ps

module hrck_back #(
    parameter int CHANNEL_BITS = hrck_pkg::CHANNEL_BITS
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             advance,
    input  logic                                             in_valid,
    input  logic [3*CHANNEL_BITS-1:0]                        in_pixel,
    input  logic [CHANNEL_BITS+hrck_pkg::SCALE_HI_SHIFT-1:0] in_rem,
    input  logic [hrck_pkg::QUO_BITS-1:0]                    in_quo,
    input  hrck_pkg::ctl_t                                   in_ctl,
    input  logic signed [hrck_pkg::HUE_BITS-1:0]             min_hue,
    input  logic signed [hrck_pkg::HUE_BITS-1:0]             max_hue,
    output logic                                             result_valid,
    output logic [hrck_pkg::OUT_BITS-1:0]                    red_out,
    output logic [hrck_pkg::OUT_BITS-1:0]                    green_out,
    output logic [hrck_pkg::OUT_BITS-1:0]                    blue_out,
    output logic [hrck_pkg::OUT_BITS-1:0]                    alpha_out,
    output logic signed [hrck_pkg::HUE_BITS-1:0]             hue,
    output logic                                             hue_undefined
);

    localparam int CB = CHANNEL_BITS;
    localparam int OB = hrck_pkg::OUT_BITS;
    localparam int HB = hrck_pkg::HUE_BITS;
    localparam int QB = hrck_pkg::QUO_BITS;

    logic                 valid_reg;
    logic [OB-1:0]        red_reg;
    logic [OB-1:0]        green_reg;
    logic [OB-1:0]        blue_reg;
    logic [OB-1:0]        alpha_reg;
    logic signed [HB-1:0] hue_reg;
    logic                 undef_reg;

    logic signed [HB:0]   quo_s;
    logic                 rem_nz;
    logic signed [HB:0]   hue_wide;
    logic signed [HB-1:0] hue_next;
    logic                 keyed;
    logic [CB+OB-1:0]     red_ext;
    logic [CB+OB-1:0]     green_ext;
    logic [CB+OB-1:0]     blue_ext;

    assign quo_s  = $signed({{(HB+1-QB){1'b0}}, in_quo});
    assign rem_nz = in_rem != '0;

    // truncation toward zero: a negative offset on a nonzero base rounds up
    always_comb
    begin
        case (in_ctl.sector)
            hrck_pkg::SECT_RED:
                if (in_ctl.neg && (in_quo != '0))
                    hue_wide = hrck_pkg::HUE_FULL_TURN - quo_s;
                else if (in_ctl.neg)
                    hue_wide = '0;
                else
                    hue_wide = quo_s;
            hrck_pkg::SECT_GREEN:
                if (in_ctl.neg)
                    hue_wide = hrck_pkg::HUE_SECT_GREEN - quo_s - (HB+1)'(rem_nz);
                else
                    hue_wide = hrck_pkg::HUE_SECT_GREEN + quo_s;
            hrck_pkg::SECT_BLUE:
                if (in_ctl.neg)
                    hue_wide = hrck_pkg::HUE_SECT_BLUE - quo_s - (HB+1)'(rem_nz);
                else
                    hue_wide = hrck_pkg::HUE_SECT_BLUE + quo_s;
            default:
                hue_wide = '0;
        endcase
        if (in_ctl.black)
            hue_wide = hrck_pkg::HUE_BLACK;
        else if (in_ctl.grey)
            hue_wide = '0;
    end

    assign hue_next = hue_wide[HB-1:0];
    assign keyed    = !in_ctl.grey && (hue_next > min_hue) && (hue_next < max_hue);

    assign red_ext   = (CB+OB)'(in_pixel[3*CB-1:2*CB]);
    assign green_ext = (CB+OB)'(in_pixel[2*CB-1:CB]);
    assign blue_ext  = (CB+OB)'(in_pixel[CB-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= keyed ? '0 : red_ext[OB-1:0];
            green_reg <= keyed ? '0 : green_ext[OB-1:0];
            blue_reg  <= keyed ? '0 : blue_ext[OB-1:0];
            alpha_reg <= keyed ? '0 : hrck_pkg::FULL_ALPHA;
            hue_reg   <= hue_next;
            undef_reg <= in_ctl.grey;
        end
    end

    assign result_valid  = valid_reg;
    assign red_out       = red_reg;
    assign green_out     = green_reg;
    assign blue_out      = blue_reg;
    assign alpha_out     = alpha_reg;
    assign hue           = hue_reg;
    assign hue_undefined = undef_reg;

endmodule

// ===== hdl/hue_range_chroma_key_top.sv =====
`timescale 1ns / 1ps

// Hue-range chroma key.
// Pixel channel: pixel_valid / pixel_stall with red_in, green_in, blue_in.
// A pixel request is taken at a clock edge with pixel_valid high and
// pixel_stall low. Result channel: result_valid / result_stall with the
// colour, alpha_out, hue and hue_undefined; a result is taken when
// result_valid is high and result_stall is low.
// Throughput: one pixel per clock while result_stall is low. A pixel
// passes through 13 register stages (two front stages, one divider
// stage per quotient bit, ten in all, and the output register).
// A pixel is keyed out (alpha and colour zero) when it is not grey and
// its hue lies strictly between min_hue and max_hue, written over the
// APB port at byte addresses 0 and 4. Write them only while no pixel is
// in flight. Reset clears every stage valid bit and both bounds to zero.
// When the receiver stalls, the output register holds its result and
// each upstream stage keeps advancing into empty slots behind it, so the
// pipeline fills up before pixel_stall rises; nothing is dropped or
// repeated.
module hue_range_chroma_key_top #(
    parameter int CHANNEL_BITS = hrck_pkg::CHANNEL_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // pixel channel
    input  logic                                  pixel_valid,
    output logic                                  pixel_stall,
    input  logic [CHANNEL_BITS-1:0]               red_in,
    input  logic [CHANNEL_BITS-1:0]               green_in,
    input  logic [CHANNEL_BITS-1:0]               blue_in,
    // result channel
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [hrck_pkg::OUT_BITS-1:0]         red_out,
    output logic [hrck_pkg::OUT_BITS-1:0]         green_out,
    output logic [hrck_pkg::OUT_BITS-1:0]         blue_out,
    output logic [hrck_pkg::OUT_BITS-1:0]         alpha_out,
    output logic signed [hrck_pkg::HUE_BITS-1:0]  hue,
    output logic                                  hue_undefined,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hrck_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [hrck_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [hrck_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                  pready
);

    localparam int CB = CHANNEL_BITS;
    localparam int DB = CB + hrck_pkg::SCALE_HI_SHIFT;
    localparam int QB = hrck_pkg::QUO_BITS;
    localparam int HB = hrck_pkg::HUE_BITS;
    localparam int PB = hrck_pkg::PDATA_BITS;

    // ---------------------------------------------------------------
    // Key range registers
    // ---------------------------------------------------------------
    logic signed [HB-1:0] min_hue_reg;
    logic signed [HB-1:0] max_hue_reg;
    logic                 reg_sel;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_hue_reg <= '0;
            max_hue_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                hrck_pkg::REG_MIN_HUE: min_hue_reg <= pwdata[HB-1:0];
                hrck_pkg::REG_MAX_HUE: max_hue_reg <= pwdata[HB-1:0];
                default: ;
            endcase
        end
    end

    // read back sign-extended
    always_comb
    begin
        case (reg_sel)
            hrck_pkg::REG_MIN_HUE: prdata = PB'(min_hue_reg);
            hrck_pkg::REG_MAX_HUE: prdata = PB'(max_hue_reg);
            default:               prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline: front (2 stages), divider (QB stages), output register
    // Index 0 of the chain arrays is the front output; index k+1 is the
    // output of divider step k.
    // ---------------------------------------------------------------
    logic              chain_valid [0:QB];
    logic [3*CB-1:0]   chain_pixel [0:QB];
    logic [CB-1:0]     chain_delta [0:QB];
    logic [DB-1:0]     chain_rem   [0:QB];
    logic [QB-1:0]     chain_quo   [0:QB];
    hrck_pkg::ctl_t    chain_ctl   [0:QB];
    logic              div_adv     [0:QB-1];
    logic              front_adv;
    logic              back_adv;

    // advance a stage when its slot is empty or the next stage advances
    assign back_adv  = !result_valid || !result_stall;
    assign front_adv = !chain_valid[0] || div_adv[0];

    hrck_front #(
        .CHANNEL_BITS (CB)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .advance     (front_adv),
        .valid       (chain_valid[0]),
        .pixel       (chain_pixel[0]),
        .delta       (chain_delta[0]),
        .dividend    (chain_rem[0]),
        .ctl         (chain_ctl[0])
    );

    // quotient starts empty; bits shift in from the top weight down
    assign chain_quo[0] = '0;

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        if (k == QB - 1)
        begin : g_last
            assign div_adv[k] = !chain_valid[k+1] || back_adv;
        end
        else
        begin : g_mid
            assign div_adv[k] = !chain_valid[k+1] || div_adv[k+1];
        end

        hrck_div_step #(
            .CHANNEL_BITS (CB),
            .SHIFT        (QB - 1 - k)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (div_adv[k]),
            .in_valid (chain_valid[k]),
            .in_pixel (chain_pixel[k]),
            .in_delta (chain_delta[k]),
            .in_rem   (chain_rem[k]),
            .in_quo   (chain_quo[k]),
            .in_ctl   (chain_ctl[k]),
            .valid    (chain_valid[k+1]),
            .pixel    (chain_pixel[k+1]),
            .delta    (chain_delta[k+1]),
            .rem      (chain_rem[k+1]),
            .quo      (chain_quo[k+1]),
            .ctl      (chain_ctl[k+1])
        );
    end

    // hue assembly, key compare and output register
    hrck_back #(
        .CHANNEL_BITS (CB)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (back_adv),
        .in_valid      (chain_valid[QB]),
        .in_pixel      (chain_pixel[QB]),
        .in_rem        (chain_rem[QB]),
        .in_quo        (chain_quo[QB]),
        .in_ctl        (chain_ctl[QB]),
        .min_hue       (min_hue_reg),
        .max_hue       (max_hue_reg),
        .result_valid  (result_valid),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .alpha_out     (alpha_out),
        .hue           (hue),
        .hue_undefined (hue_undefined)
    );

endmodule
